@@ rtl/lspe_pkg.sv @@
// Shared constants, types and tables of the line sensor position estimator.
`timescale 1ns / 1ps

package lspe_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 10;

   localparam int NUM_CH      = 5;
   localparam int CH_W        = 3;
   localparam int NORM_W      = 10;
   localparam int SCALE       = 1000;
   localparam int SCALE_W     = 10;
   localparam int RSUM_W      = 13;
   localparam int WSUM_W      = 24;
   localparam int WEIGHT_W    = 12;
   localparam int PROD_W      = WEIGHT_W + NORM_W;
   localparam int POS_W       = 12;
   localparam int CLASS_W     = 3;
   localparam int CFG_W       = 10;
   localparam int CSR_INDEX_W = 3;

   localparam int MIN_RESET = 255;
   localparam int MAX_RESET = 980;

   localparam logic [CFG_W-1:0] LIFT_RESET   = CFG_W'(150);
   localparam logic [CFG_W-1:0] DARK_RESET   = CFG_W'(500);
   localparam logic [CFG_W-1:0] BRIGHT_RESET = CFG_W'(800);
   localparam logic [CFG_W-1:0] SIDE_RESET   = CFG_W'(750);
   localparam logic [CFG_W-1:0] MIDDLE_RESET = CFG_W'(530);

   localparam logic [CH_W-1:0] CHANNEL_LAST = CH_W'(NUM_CH - 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LIFT_LEVEL   = 3'd0,
      CSR_DARK_LEVEL   = 3'd1,
      CSR_BRIGHT_LEVEL = 3'd2,
      CSR_SIDE_LEVEL   = 3'd3,
      CSR_MIDDLE_LEVEL = 3'd4
   } csr_index_type;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_NONE         = 3'd0,
      CLASS_RIGHT_BRANCH = 3'd1,
      CLASS_LEFT_BRANCH  = 3'd2,
      CLASS_CROSSING     = 3'd3,
      CLASS_CENTERED     = 3'd4
   } line_class_type;

   typedef enum logic {
      DIV_NORM = 1'b0,
      DIV_POS  = 1'b1
   } div_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_sample;
      logic        update_range;
      logic        scale;
      logic        div_start;
      div_sel_type div_sel;
      logic        store_norm;
      logic        acc_weight;
      logic        finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic last_channel;
      logic out_free;
   } sts_type;

   // Centroid weight of a channel: channel number times 1000.
   function automatic logic [WEIGHT_W-1:0] channel_weight(input logic [CH_W-1:0] ch);
      logic [WEIGHT_W-1:0] w;
      unique case (ch)
         3'd0:    w = WEIGHT_W'(0);
         3'd1:    w = WEIGHT_W'(1000);
         3'd2:    w = WEIGHT_W'(2000);
         3'd3:    w = WEIGHT_W'(3000);
         3'd4:    w = WEIGHT_W'(4000);
         default: w = WEIGHT_W'(0);
      endcase
      return w;
   endfunction

endpackage

@@ rtl/line_sensor_position_estimator.sv @@
// Top level of the line sensor position estimator.
`timescale 1ns / 1ps

// Raw reflectance samples of a five-sensor line array enter one beat at a time in
// channel order 0 to 4, and every fifth beat produces one result beat with the
// weighted centroid of the normalized readings (0 to 4000, sensor k weighted
// k*1000, 0 when all readings are zero), a line pattern class and a lifted flag.
// Each sample first moves the shared running minimum or maximum, is then scaled to
// 0..1000 against that range, and is added into the frame sums. Both the scaling
// and the final centroid use one shared bit-serial divider that produces one
// quotient bit per cycle over a 24-bit dividend, so a sample holds the block
// from its beat to the next ready through the accepting cycle, moving the
// range, scaling, starting the divider, the 24 quotient bits and the done flag,
// and storing and accumulating. The fifth sample of a frame then adds the
// centroid division: start, division and loading of the output register.
// Samples are taken one at a time; a new sample is accepted while an earlier
// result still waits in the output register, and the block only holds off
// loading a new result until the old one has been taken. The five threshold
// registers may be written at any time the block is idle, one per cycle, with
// no read-back; writes to indexes beyond the last register are dropped and only
// the low 10 bits of the data are kept.
module line_sensor_position_estimator
   import lspe_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_raw_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [POS_W-1:0]       rsp_line_position,
   output logic [CLASS_W-1:0]     rsp_line_class,
   output logic                   rsp_lifted,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // The controller walks each sample through its steps and decides when a frame
   // is complete; all arithmetic and storage live in the datapath.
   lspe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lspe_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_raw_sample    (req_raw_sample),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_position (rsp_line_position),
      .rsp_line_class    (rsp_line_class),
      .rsp_lifted        (rsp_lifted)
   );

`ifndef SYNTHESIS
   // Once a sample beat is taken, the block is busy with it on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted again right after a sample beat");

   // The divider is never restarted while it still works on a quotient.
   a_div_not_restarted: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider started while busy");

   // A result is only formed on the last channel of a frame.
   a_finish_last_channel: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> sts.last_channel)
      else $error("result formed before the fifth channel");

   // Forming a result always presents it on the output.
   a_finish_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("result formed but not presented");
`endif

endmodule

@@ rtl/lspe_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module lspe_div #(
   parameter int DIVIDEND_W = 24,
   parameter int DIVISOR_W  = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dvs_ff;

   logic [DIVISOR_W:0]    rem_shift;
   logic                  fits;
   logic [DIVISOR_W:0]    rem_diff;

   // Bring down the next dividend bit and try a subtraction.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
         rem_ff <= fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/lspe_dp.sv @@
// Datapath: range tracking, normalization, sums, classification and result register.
`timescale 1ns / 1ps

module lspe_dp
   import lspe_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SAMPLE_BITS-1:0] req_raw_sample,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata,
   input  cmd_type                cmd,
   output sts_type                sts,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [POS_W-1:0]       rsp_line_position,
   output logic [CLASS_W-1:0]     rsp_line_class,
   output logic                   rsp_lifted
);

   localparam int RANGE_W    = (SAMPLE_BITS > NORM_W) ? SAMPLE_BITS : NORM_W;
   localparam int NUMER_W    = RANGE_W + SCALE_W;
   localparam int DIVIDEND_W = (NUMER_W > WSUM_W) ? NUMER_W : WSUM_W;
   localparam int DIVISOR_W  = (RANGE_W > RSUM_W) ? RANGE_W : RSUM_W;

   // Configuration registers.
   logic [CFG_W-1:0] lift_ff, dark_ff, bright_ff, side_ff, middle_ff;

   // Frame state.
   logic [RANGE_W-1:0] min_ff, max_ff;
   logic [CH_W-1:0]    channel_ff;
   logic [RSUM_W-1:0]  rsum_ff;
   logic [WSUM_W-1:0]  wsum_ff;
   logic               rsp_valid_ff;

   // Working registers.
   logic [RANGE_W-1:0] sample_ff;
   logic [RANGE_W-1:0] span_ff;
   logic               span_zero_ff;
   logic [NUMER_W-1:0] numer_ff;
   logic [PROD_W-1:0]  product_ff;
   logic [NORM_W-1:0]  store_ff [NUM_CH];
   logic [POS_W-1:0]   pos_ff;
   logic [CLASS_W-1:0] class_ff;
   logic               lifted_ff;

   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic [DIVIDEND_W-1:0] div_quotient;
   logic                  div_busy;
   logic                  div_done;

   logic [NORM_W-1:0]  norm;
   logic [RANGE_W-1:0] span_in;
   logic [NUMER_W-1:0] numer_in;
   logic [POS_W-1:0]   pos_in;
   line_class_type     class_in;
   logic               lifted_in;

   always_comb begin
      unique case (cmd.div_sel)
         DIV_NORM: begin
            div_dividend = DIVIDEND_W'(numer_ff);
            div_divisor  = DIVISOR_W'(span_ff);
         end
         DIV_POS: begin
            div_dividend = DIVIDEND_W'(wsum_ff);
            div_divisor  = DIVISOR_W'(rsum_ff);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   lspe_div #(
      .DIVIDEND_W (DIVIDEND_W),
      .DIVISOR_W  (DIVISOR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      span_in  = (max_ff > min_ff) ? max_ff - min_ff : '0;
      numer_in = (sample_ff >= min_ff)
                 ? NUMER_W'(sample_ff - min_ff) * NUMER_W'(SCALE) : '0;
      norm     = span_zero_ff ? '0 : div_quotient[NORM_W-1:0];
      pos_in   = (rsum_ff == '0) ? '0 : div_quotient[POS_W-1:0];
   end

   // Pattern classes in priority order; the first match wins.
   always_comb begin
      lifted_in = 1'b1;
      for (int k = 0; k < NUM_CH; k++) begin
         if (store_ff[k] >= lift_ff) begin
            lifted_in = 1'b0;
         end
      end
      priority if (store_ff[0] > bright_ff && store_ff[2] < dark_ff &&
                   store_ff[3] < dark_ff && store_ff[4] < dark_ff) begin
         class_in = CLASS_RIGHT_BRANCH;
      end else if (store_ff[0] < dark_ff && store_ff[1] < dark_ff &&
                   store_ff[2] < dark_ff && store_ff[4] > bright_ff) begin
         class_in = CLASS_LEFT_BRANCH;
      end else if (store_ff[0] < dark_ff && store_ff[1] < dark_ff &&
                   store_ff[2] < dark_ff && store_ff[3] < dark_ff &&
                   store_ff[4] < dark_ff) begin
         class_in = CLASS_CROSSING;
      end else if (store_ff[0] > side_ff && store_ff[1] > side_ff &&
                   store_ff[2] < middle_ff && store_ff[3] > side_ff &&
                   store_ff[4] > side_ff) begin
         class_in = CLASS_CENTERED;
      end else begin
         class_in = CLASS_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lift_ff      <= LIFT_RESET;
         dark_ff      <= DARK_RESET;
         bright_ff    <= BRIGHT_RESET;
         side_ff      <= SIDE_RESET;
         middle_ff    <= MIDDLE_RESET;
         min_ff       <= RANGE_W'(MIN_RESET);
         max_ff       <= RANGE_W'(MAX_RESET);
         channel_ff   <= '0;
         rsum_ff      <= '0;
         wsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_LIFT_LEVEL:   lift_ff   <= csr_wdata;
               CSR_DARK_LEVEL:   dark_ff   <= csr_wdata;
               CSR_BRIGHT_LEVEL: bright_ff <= csr_wdata;
               CSR_SIDE_LEVEL:   side_ff   <= csr_wdata;
               CSR_MIDDLE_LEVEL: middle_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.update_range) begin
            if (sample_ff < min_ff) begin
               min_ff <= sample_ff;
            end else if (sample_ff > max_ff) begin
               max_ff <= sample_ff;
            end
         end
         if (cmd.store_norm) begin
            rsum_ff <= rsum_ff + RSUM_W'(norm);
         end
         if (cmd.acc_weight) begin
            wsum_ff <= wsum_ff + WSUM_W'(product_ff);
            if (channel_ff != CHANNEL_LAST) begin
               channel_ff <= channel_ff + CH_W'(1);
            end
         end
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            channel_ff   <= '0;
            rsum_ff      <= '0;
            wsum_ff      <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_ff <= RANGE_W'(req_raw_sample);
      end
      if (cmd.scale) begin
         span_ff      <= span_in;
         span_zero_ff <= (span_in == '0);
         numer_ff     <= numer_in;
      end
      if (cmd.store_norm) begin
         store_ff[channel_ff] <= norm;
         product_ff <= PROD_W'(channel_weight(channel_ff)) * PROD_W'(norm);
      end
      if (cmd.finish) begin
         pos_ff    <= pos_in;
         class_ff  <= class_in;
         lifted_ff <= lifted_in;
      end
   end

   always_comb begin
      sts.div_busy     = div_busy;
      sts.div_done     = div_done;
      sts.last_channel = (channel_ff == CHANNEL_LAST);
      sts.out_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_position = pos_ff;
   assign rsp_line_class    = class_ff;
   assign rsp_lifted        = lifted_ff;

endmodule

@@ rtl/lspe_ctrl.sv @@
// Controller: sequences one sample through the datapath and closes each frame.
`timescale 1ns / 1ps

module lspe_ctrl
   import lspe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RANGE,
      ST_SCALE,
      ST_NORM_GO,
      ST_NORM_WAIT,
      ST_STORE,
      ST_ACC,
      ST_POS_GO,
      ST_POS_WAIT,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_sample = req_valid;
            if (req_valid) begin
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            cmd.update_range = 1'b1;
            state_in         = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_NORM_GO;
         end
         ST_NORM_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_NORM;
            state_in      = ST_NORM_WAIT;
         end
         ST_NORM_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store_norm = 1'b1;
            state_in       = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_weight = 1'b1;
            state_in       = sts.last_channel ? ST_POS_GO : ST_IDLE;
         end
         ST_POS_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_POS;
            state_in      = ST_POS_WAIT;
         end
         ST_POS_WAIT: begin
            cmd.div_sel = DIV_POS;
            if (sts.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.div_sel = DIV_POS;
            cmd.finish  = sts.out_free;
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule
